/* rtl/core/sct_pkg.sv */
`default_nettype none

package sct_pkg;

	localparam int RES_W       = 16;
	localparam int DEPTH_OUT_W = 7;

	localparam logic [2:0] CMD_CALL   = 3'd0;
	localparam logic [2:0] CMD_RETURN = 3'd1;
	localparam logic [2:0] CMD_COUNT  = 3'd2;
	localparam logic [2:0] CMD_FLAG   = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_TABLE_FULL  = 2'd1;
	localparam logic [1:0] ST_STACK_FULL  = 2'd2;
	localparam logic [1:0] ST_STACK_EMPTY = 2'd3;

	localparam logic [RES_W-1:0] SIZE_MAX = {RES_W{1'b1}};

	typedef struct packed {
		logic done;
		logic hit;
	} scan_stat_t;

endpackage

`default_nettype wire

/* rtl/core/sct_ram.sv */
`default_nettype none

module sct_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/sct_scan.sv */
`default_nettype none

module sct_scan #(
	parameter int CNT_W = 9,
	parameter int IDX_W = 8,
	parameter int AW    = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                go,
	input  wire logic [CNT_W-1:0]    count,
	input  wire logic [AW-1:0]       key,
	input  wire logic [AW-1:0]       rdata,
	output logic                     rd_en,
	output logic      [IDX_W-1:0]    rd_addr,
	output sct_pkg::scan_stat_t      stat
);

	logic             active_q;
	logic             pend_q;
	logic [CNT_W-1:0] idx_q;
	logic             hit_now;
	logic             more;

	assign hit_now   = pend_q && (rdata == key);
	assign more      = (idx_q != count);
	assign stat.hit  = hit_now;
	assign stat.done = active_q && (hit_now || !more);
	assign rd_en     = active_q && !hit_now && more;
	assign rd_addr   = idx_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pend_q   <= 1'b0;
			idx_q    <= '0;
		end else if (go) begin
			active_q <= 1'b1;
			pend_q   <= 1'b0;
			idx_q    <= '0;
		end else if (active_q) begin
			if (stat.done) begin
				active_q <= 1'b0;
			end
			pend_q <= rd_en;
			if (rd_en) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/subroutine_call_tracker_unit.sv */
`default_nettype none

// Subroutine call tracker. An item is taken when start is high and busy is low;
// its result appears on the result ports for exactly one cycle with done high
// and must be captured then, since the receiver cannot hold it off. Every item
// first scans the visited-address table through its single read port, one
// compare per cycle, ending early when the address is found, and busy falls in
// the cycle that done is shown.
module subroutine_call_tracker_unit #(
	parameter int MAX_SUBROUTINES = 256,
	parameter int STACK_DEPTH     = 64,
	parameter int ADDR_BITS       = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [2:0]                      command,
	input  wire logic [ADDR_BITS-1:0]            address,
	input  wire logic [ADDR_BITS-1:0]            link_address,
	output logic                                 done,
	output logic                                 address_seen,
	output logic                                 first_call,
	output logic [sct_pkg::RES_W-1:0]            return_address,
	output logic [sct_pkg::RES_W-1:0]            finished_start,
	output logic [sct_pkg::RES_W-1:0]            finished_size,
	output logic [sct_pkg::DEPTH_OUT_W-1:0]      nest_depth,
	output logic                                 conditional_pending,
	output logic [1:0]                           status
);

	localparam int RES_W   = sct_pkg::RES_W;
	localparam int DOUT_W  = sct_pkg::DEPTH_OUT_W;
	localparam int IDX_W   = $clog2(MAX_SUBROUTINES);
	localparam int CNT_W   = $clog2(MAX_SUBROUTINES + 1);
	localparam int SP_W    = $clog2(STACK_DEPTH);
	localparam int SD_W    = $clog2(STACK_DEPTH + 1);
	localparam int STK_W   = ADDR_BITS + 2 + IDX_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_EXEC   = 3'd2;
	localparam logic [2:0] S_POP    = 3'd3;
	localparam logic [2:0] S_CNT    = 3'd4;

	logic [2:0]           state_q, state_d;
	logic [2:0]           cmd_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [ADDR_BITS-1:0] link_q;
	logic                 seen_q;
	logic [CNT_W-1:0]     vcount_q, vcount_d;
	logic [SD_W-1:0]      depth_q, depth_d;
	logic                 cur_valid_q, cur_valid_d;
	logic [IDX_W-1:0]     cur_idx_q, cur_idx_d;
	logic                 cond_q, cond_d;
	logic                 done_q;
	logic                 first_q;
	logic [RES_W-1:0]     ret_q, fstart_q, fsize_q;
	logic [1:0]           status_q;

	logic                 fin;
	logic                 first_n;
	logic [RES_W-1:0]     ret_n, fstart_n, fsize_n;
	logic [1:0]           status_n;

	logic                 scan_go;
	logic                 scan_re;
	logic [IDX_W-1:0]     scan_ra;
	sct_pkg::scan_stat_t  scan_stat;

	logic                 vis_we, vis_re;
	logic [IDX_W-1:0]     vis_wa, vis_ra;
	logic [ADDR_BITS-1:0] vis_rdata;

	logic                 sz_we, sz_re;
	logic [IDX_W-1:0]     sz_wa;
	logic [RES_W-1:0]     sz_wd, sz_rdata;

	logic                 stk_we, stk_re;
	logic [SP_W-1:0]      stk_wa, stk_ra;
	logic [STK_W-1:0]     stk_wd, stk_rdata;
	logic [ADDR_BITS-1:0] stk_link;
	logic                 stk_cond;
	logic                 stk_cvalid;
	logic [IDX_W-1:0]     stk_cidx;

	assign stk_link   = stk_rdata[STK_W-1 -: ADDR_BITS];
	assign stk_cond   = stk_rdata[IDX_W+1];
	assign stk_cvalid = stk_rdata[IDX_W];
	assign stk_cidx   = stk_rdata[IDX_W-1:0];

	sct_scan #(
		.CNT_W(CNT_W),
		.IDX_W(IDX_W),
		.AW   (ADDR_BITS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (scan_go),
		.count  (vcount_q),
		.key    (addr_q),
		.rdata  (vis_rdata),
		.rd_en  (scan_re),
		.rd_addr(scan_ra),
		.stat   (scan_stat)
	);

	sct_ram #(
		.WIDTH(ADDR_BITS),
		.DEPTH(MAX_SUBROUTINES)
	) u_visited (
		.clk  (clk),
		.we   (vis_we),
		.waddr(vis_wa),
		.wdata(addr_q),
		.re   (vis_re),
		.raddr(vis_ra),
		.rdata(vis_rdata)
	);

	sct_ram #(
		.WIDTH(RES_W),
		.DEPTH(MAX_SUBROUTINES)
	) u_size (
		.clk  (clk),
		.we   (sz_we),
		.waddr(sz_wa),
		.wdata(sz_wd),
		.re   (sz_re),
		.raddr(cur_idx_q),
		.rdata(sz_rdata)
	);

	sct_ram #(
		.WIDTH(STK_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_wa),
		.wdata(stk_wd),
		.re   (stk_re),
		.raddr(stk_ra),
		.rdata(stk_rdata)
	);

	always_comb begin
		state_d     = state_q;
		vcount_d    = vcount_q;
		depth_d     = depth_q;
		cur_valid_d = cur_valid_q;
		cur_idx_d   = cur_idx_q;
		cond_d      = cond_q;
		fin         = 1'b0;
		first_n     = 1'b0;
		ret_n       = '0;
		fstart_n    = '0;
		fsize_n     = '0;
		status_n    = sct_pkg::ST_OK;
		scan_go     = 1'b0;
		vis_we      = 1'b0;
		vis_wa      = vcount_q[IDX_W-1:0];
		vis_re      = scan_re;
		vis_ra      = scan_ra;
		sz_we       = 1'b0;
		sz_wa       = vcount_q[IDX_W-1:0];
		sz_wd       = '0;
		sz_re       = 1'b0;
		stk_we      = 1'b0;
		stk_wa      = depth_q[SP_W-1:0];
		stk_wd      = {link_q, cond_q, cur_valid_q, cur_idx_q};
		stk_re      = 1'b0;
		stk_ra      = SP_W'(depth_q - 1'b1);

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					scan_go = 1'b1;
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (scan_stat.done) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (cmd_q)
					sct_pkg::CMD_CALL: begin
						fin = 1'b1;
						if (seen_q) begin
							status_n = sct_pkg::ST_OK;
						end else if (vcount_q == CNT_W'(MAX_SUBROUTINES)) begin
							status_n = sct_pkg::ST_TABLE_FULL;
						end else if (depth_q == SD_W'(STACK_DEPTH)) begin
							status_n = sct_pkg::ST_STACK_FULL;
						end else begin
							stk_we      = 1'b1;
							vis_we      = 1'b1;
							sz_we       = 1'b1;
							depth_d     = depth_q + 1'b1;
							vcount_d    = vcount_q + 1'b1;
							cond_d      = 1'b0;
							cur_valid_d = 1'b1;
							cur_idx_d   = vcount_q[IDX_W-1:0];
							first_n     = 1'b1;
						end
					end
					sct_pkg::CMD_RETURN: begin
						if (depth_q == '0) begin
							status_n = sct_pkg::ST_STACK_EMPTY;
							fin      = 1'b1;
						end else begin
							stk_re  = 1'b1;
							vis_re  = cur_valid_q;
							vis_ra  = cur_idx_q;
							sz_re   = cur_valid_q;
							state_d = S_POP;
						end
					end
					sct_pkg::CMD_COUNT: begin
						if (cur_valid_q) begin
							sz_re   = 1'b1;
							state_d = S_CNT;
						end else begin
							fin = 1'b1;
						end
					end
					sct_pkg::CMD_FLAG: begin
						cond_d = 1'b1;
						fin    = 1'b1;
					end
					sct_pkg::CMD_CLEAR: begin
						vcount_d    = '0;
						depth_d     = '0;
						cur_valid_d = 1'b0;
						fin         = 1'b1;
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			S_POP: begin
				ret_n       = RES_W'(stk_link);
				fstart_n    = cur_valid_q ? RES_W'(vis_rdata) : '0;
				fsize_n     = cur_valid_q ? sz_rdata : '0;
				depth_d     = depth_q - 1'b1;
				cond_d      = stk_cond;
				cur_valid_d = stk_cvalid;
				cur_idx_d   = stk_cidx;
				fin         = 1'b1;
			end
			S_CNT: begin
				if (sz_rdata != sct_pkg::SIZE_MAX) begin
					sz_we = 1'b1;
					sz_wa = cur_idx_q;
					sz_wd = sz_rdata + 1'b1;
				end
				fin = 1'b1;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (fin) begin
			state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vcount_q    <= '0;
			depth_q     <= '0;
			cur_valid_q <= 1'b0;
			cond_q      <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			vcount_q    <= vcount_d;
			depth_q     <= depth_d;
			cur_valid_q <= cur_valid_d;
			cond_q      <= cond_d;
			done_q      <= fin;
		end
	end

	always_ff @(posedge clk) begin
		cur_idx_q <= cur_idx_d;
		if (state_q == S_IDLE && start) begin
			cmd_q  <= command;
			addr_q <= address;
			link_q <= link_address;
		end
		if (state_q == S_SEARCH && scan_stat.done) begin
			seen_q <= scan_stat.hit;
		end
		if (fin) begin
			first_q  <= first_n;
			ret_q    <= ret_n;
			fstart_q <= fstart_n;
			fsize_q  <= fsize_n;
			status_q <= status_n;
		end
	end

	assign busy                = (state_q != S_IDLE);
	assign done                = done_q;
	assign address_seen        = seen_q;
	assign first_call          = first_q;
	assign return_address      = ret_q;
	assign finished_start      = fstart_q;
	assign finished_size       = fsize_q;
	assign nest_depth          = DOUT_W'(depth_q);
	assign conditional_pending = cond_q;
	assign status              = status_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while an item is still in work");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= SD_W'(STACK_DEPTH))
		else $error("call stack depth beyond its size");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vcount_q <= CNT_W'(MAX_SUBROUTINES))
		else $error("visited count beyond table size");

	a_first_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(done && first_call) |-> (cur_valid_q && depth_q != '0))
		else $error("new record reported without an open record");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_SEARCH))
		else $error("accepted transfer did not start the table scan");
`endif

endmodule

`default_nettype wire
